// ===== sv/montgomery_modular_alu_macros.svh =====
// Assertion helpers for the modular ALU.
`ifndef MONTGOMERY_MODULAR_ALU_MACROS_SVH
`define MONTGOMERY_MODULAR_ALU_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define MMA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while in reset.
`define MMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mma_pkg.sv =====
`default_nettype none
package mma_pkg;

  // Field widths
  localparam int unsigned OPW   = 4;
  localparam int unsigned VALW  = 31;
  localparam int unsigned WORDW = 32;
  localparam int unsigned MODW  = 30;
  localparam int unsigned WIDEW = 64;
  localparam int unsigned CFGAW = 2;

  // Divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = WIDEW;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS + 1);

  // Opcodes
  localparam logic [OPW-1:0] OP_TOMONT  = 4'd0;
  localparam logic [OPW-1:0] OP_ADD     = 4'd1;
  localparam logic [OPW-1:0] OP_SUB     = 4'd2;
  localparam logic [OPW-1:0] OP_MUL     = 4'd3;
  localparam logic [OPW-1:0] OP_DIV     = 4'd4;
  localparam logic [OPW-1:0] OP_POW     = 4'd5;
  localparam logic [OPW-1:0] OP_INV     = 4'd6;
  localparam logic [OPW-1:0] OP_TOPLAIN = 4'd7;
  localparam logic [OPW-1:0] OP_EQ      = 4'd8;
  localparam logic [OPW-1:0] OP_NEG     = 4'd9;

  // Configuration register indexes
  localparam logic [CFGAW-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFGAW-1:0] CFG_NEG_INV = 2'd1;
  localparam logic [CFGAW-1:0] CFG_R2      = 2'd2;

  // Divider request and status
  typedef struct packed {
    logic             start;
    logic [WIDEW-1:0] dividend;
    logic [MODW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== sv/mma_intf.sv =====
`default_nettype none
// Operation request channel
interface mma_in_if;
  logic                              valid;
  logic                              ready;
  logic [mma_pkg::OPW-1:0]           opcode;
  logic [mma_pkg::VALW-1:0]          operand_a;
  logic [mma_pkg::VALW-1:0]          operand_b;
  logic [mma_pkg::WIDEW-1:0]         exponent;
  logic signed [mma_pkg::WIDEW-1:0]  plain_value;
  modport source (output valid, opcode, operand_a, operand_b, exponent, plain_value,
                  input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, exponent, plain_value,
                  output ready);
endinterface

// Result channel
interface mma_out_if;
  logic                     valid;
  logic                     ready;
  logic [mma_pkg::VALW-1:0] result;
  logic                     equal;
  modport source (output valid, result, equal, input ready);
  modport sink   (input valid, result, equal, output ready);
endinterface

// Register write channel
interface mma_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mma_pkg::CFGAW-1:0]  addr;
  logic [mma_pkg::WORDW-1:0]  data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== sv/mma_mul.sv =====
`default_nettype none
// Shared 32x32 multiplier, product registered
module mma_mul (
  input  wire logic                          clk_i,
  input  wire logic [mma_pkg::WORDW-1:0]     a_i,
  input  wire logic [mma_pkg::WORDW-1:0]     b_i,
  output logic      [2*mma_pkg::WORDW-1:0]   p_o
);

  logic [2*mma_pkg::WORDW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== sv/mma_div.sv =====
`default_nettype none
// Restoring divider: 64-bit dividend by 30-bit divisor, one bit per cycle
module mma_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mma_pkg::div_req_t           req_i,
  output mma_pkg::div_stat_t               stat_o,
  output logic [mma_pkg::WIDEW-1:0]        quot_o,
  output logic [mma_pkg::MODW-1:0]         rem_o
);

  logic [mma_pkg::DIV_CW-1:0] cnt_q;
  logic                       busy_q, done_q;
  logic [mma_pkg::WIDEW-1:0]  num_q;
  logic [mma_pkg::MODW-1:0]   rem_q, den_q;
  logic [mma_pkg::MODW:0]     trial;
  logic                       fits;

  // Shift in the next dividend bit and try to subtract
  assign trial = {rem_q, num_q[mma_pkg::WIDEW-1]};
  assign fits  = trial >= {1'b0, den_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= mma_pkg::DIV_CW'(mma_pkg::DIV_STEPS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mma_pkg::DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[mma_pkg::WIDEW-2:0], fits};
      rem_q <= fits ? mma_pkg::MODW'(trial - {1'b0, den_q}) : trial[mma_pkg::MODW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = num_q;
  assign rem_o       = rem_q;

endmodule
`default_nettype wire

// ===== sv/montgomery_modular_alu.sv =====
// Inverse and divide: Euclid steps, each a divide and a multiply, plus tomont.
// Power: a tomont of one, then a square per exponent bit up to its top set bit, plus a multiply per set bit.
// Throughput is one item at a time, set by the shared multiplier and the 1-bit divider.
// Reset: asynchronous active low; registers return to modulus 1, neg_inv all ones, r2 0.
`default_nettype none
`include "montgomery_modular_alu_macros.svh"
module montgomery_modular_alu (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mma_in_if.sink    in_i,
  mma_out_if.source out_o,
  mma_cfg_if.sink   cfg_i
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SMP   = 16'h0002,
    S_DIVGO = 16'h0004,
    S_DIVW  = 16'h0008,
    S_TMM   = 16'h0010,
    S_TLD   = 16'h0020,
    S_RA    = 16'h0040,
    S_RB    = 16'h0080,
    S_RC    = 16'h0100,
    S_EU    = 16'h0200,
    S_EUW   = 16'h0400,
    S_EUM   = 16'h0800,
    S_PW    = 16'h1000,
    S_PSQ   = 16'h2000,
    S_DMUL  = 16'h4000,
    S_FIN   = 16'h8000
  } state_e;

  // Where a finished reduction goes
  typedef enum logic [5:0] {
    DST_FIN   = 6'b000001,
    DST_PLAIN = 6'b000010,
    DST_X1    = 6'b000100,
    DST_TM    = 6'b001000,
    DST_ACC   = 6'b010000,
    DST_BASE  = 6'b100000
  } dst_e;

  localparam int unsigned W  = mma_pkg::WORDW;
  localparam int unsigned WW = mma_pkg::WIDEW;
  localparam int unsigned MW = mma_pkg::MODW;
  localparam int unsigned VW = mma_pkg::VALW;

  state_e state_q;
  dst_e   dst_q;

  logic [MW-1:0] modulus_q, r2_q;
  logic [W-1:0]  ninv_q;

  logic                  out_valid_q, out_eq_q, eq_q;
  logic [VW-1:0]         out_res_q;
  logic [mma_pkg::OPW-1:0] op_q;
  logic [VW-1:0]         a_q, b_q;
  logic [WW-1:0]         e_q, pv_q, t_q;
  logic [W-1:0]          acc_q, base_q, res_q;
  logic [W-1:0]          x1_q, x2_q, y2_q;
  logic [MW-1:0]         y1_q;

  logic [MW-1:0]   m;
  logic [W-1:0]    m32, m2;
  logic [W-1:0]    mul_a, mul_b;
  logic [2*W-1:0]  prod;
  logic [WW-1:0]   redc_sum, pv_mag;
  logic [W-1:0]    r, rr;
  mma_pkg::div_req_t  div_req;
  mma_pkg::div_stat_t div_stat;
  logic [WW-1:0]   div_quot;
  logic [MW-1:0]   div_rem;
  logic [W-1:0]    smp_v, smp_fix;
  logic [VW-1:0]   ra, rb;
  logic            in_xfer, out_free;

  // Effective modulus is always odd
  assign m   = {modulus_q[MW-1:1], 1'b1};
  assign m32 = W'(m);
  assign m2  = W'({m, 1'b0});

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_res_q;
  assign out_o.equal  = out_eq_q;

  // Reduction tail and final conditional subtract
  assign redc_sum = t_q + prod;
  assign r        = redc_sum[WW-1:W];
  assign rr       = (r >= m32) ? r - m32 : r;

  assign pv_mag = pv_q[WW-1] ? WW'(0) - pv_q : pv_q;

  // Add, sub, neg with 2m correction
  always_comb begin
    case (op_q)
      mma_pkg::OP_ADD: smp_v = W'(a_q) + W'(b_q) - m2;
      mma_pkg::OP_SUB: smp_v = W'(a_q) - W'(b_q);
      mma_pkg::OP_NEG: smp_v = W'(0) - W'(a_q);
      default:         smp_v = '0;
    endcase
  end
  assign smp_fix = smp_v[W-1] ? smp_v + m2 : smp_v;
  assign ra = (W'(a_q) >= m32) ? VW'(W'(a_q) - m32) : a_q;
  assign rb = (W'(b_q) >= m32) ? VW'(W'(b_q) - m32) : b_q;

  // Multiplier operand select
  always_comb begin
    case (state_q)
      S_TMM:   begin mul_a = t_q[W-1:0];         mul_b = W'(r2_q); end
      S_RA:    begin mul_a = t_q[W-1:0];         mul_b = ninv_q;   end
      S_RB:    begin mul_a = prod[W-1:0];        mul_b = m32;      end
      S_DMUL:  begin mul_a = W'(a_q);            mul_b = acc_q;    end
      S_PW:    begin mul_a = e_q[0] ? acc_q : base_q; mul_b = base_q; end
      S_PSQ:   begin mul_a = base_q;             mul_b = base_q;   end
      S_EUW:   begin mul_a = div_quot[W-1:0];    mul_b = y2_q;     end
      default: begin mul_a = '0;                 mul_b = '0;       end
    endcase
  end

  mma_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Divider requests: tomont residue and Euclid quotient
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = pv_mag;
    div_req.divisor  = m;
    if (state_q == S_DIVGO) begin
      div_req.start = 1'b1;
    end else if (state_q == S_EU) begin
      div_req.start    = (y1_q != '0);
      div_req.dividend = WW'(x1_q);
      div_req.divisor  = y1_q;
    end
  end

  mma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  // Sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dst_q       <= DST_FIN;
      out_valid_q <= 1'b0;
      modulus_q   <= MW'(1);
      ninv_q      <= '1;
      r2_q        <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.addr)
          mma_pkg::CFG_MODULUS: modulus_q <= cfg_i.data[MW-1:0];
          mma_pkg::CFG_NEG_INV: ninv_q    <= cfg_i.data;
          mma_pkg::CFG_R2:      r2_q      <= cfg_i.data[MW-1:0];
          default: ;
        endcase
      end
      // Result transfer frees the output unless a new result loads it
      if (out_valid_q && out_o.ready && state_q != S_FIN) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_i.opcode)
              mma_pkg::OP_TOMONT,
              mma_pkg::OP_POW:     begin dst_q <= DST_TM;    state_q <= S_DIVGO; end
              mma_pkg::OP_MUL:     begin dst_q <= DST_FIN;   state_q <= S_DMUL;  end
              mma_pkg::OP_TOPLAIN: begin dst_q <= DST_PLAIN; state_q <= S_RA;    end
              mma_pkg::OP_INV,
              mma_pkg::OP_DIV:     begin dst_q <= DST_X1;    state_q <= S_RA;    end
              default:             state_q <= S_SMP;
            endcase
          end
        end
        S_SMP:   state_q <= S_FIN;
        S_DIVGO: state_q <= S_DIVW;
        S_DIVW:  if (div_stat.done) state_q <= S_TMM;
        S_TMM:   state_q <= S_TLD;
        S_TLD:   state_q <= S_RA;
        S_RA:    state_q <= S_RB;
        S_RB:    state_q <= S_RC;
        S_RC: begin
          case (dst_q)
            DST_X1:   state_q <= S_EU;
            DST_ACC:  begin dst_q <= DST_BASE; state_q <= S_PSQ; end
            DST_BASE: state_q <= S_PW;
            DST_TM: begin
              if (op_q == mma_pkg::OP_DIV) begin
                dst_q   <= DST_FIN;
                state_q <= S_DMUL;
              end else if (op_q == mma_pkg::OP_POW) begin
                state_q <= S_PW;
              end else begin
                state_q <= S_FIN;
              end
            end
            default:  state_q <= S_FIN;
          endcase
        end
        S_EU: begin
          if (y1_q == '0) begin
            dst_q   <= DST_TM;
            state_q <= S_DIVGO;
          end else begin
            state_q <= S_EUW;
          end
        end
        S_EUW:   if (div_stat.done) state_q <= S_EUM;
        S_EUM:   state_q <= S_EU;
        S_PW: begin
          if (e_q == '0) begin
            state_q <= S_FIN;
          end else begin
            dst_q   <= e_q[0] ? DST_ACC : DST_BASE;
            state_q <= S_TLD;
          end
        end
        S_PSQ:   state_q <= S_TLD;
        S_DMUL:  state_q <= S_TLD;
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Operand and working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_q  <= in_i.opcode;
          a_q   <= in_i.operand_a;
          b_q   <= in_i.operand_b;
          e_q   <= in_i.exponent;
          eq_q  <= 1'b0;
          res_q <= '0;
          acc_q <= W'(in_i.operand_b);
          pv_q  <= (in_i.opcode == mma_pkg::OP_POW) ? WW'(1) : in_i.plain_value;
          t_q   <= (in_i.opcode == mma_pkg::OP_DIV) ? WW'(in_i.operand_b)
                                                    : WW'(in_i.operand_a);
        end
      end
      S_SMP: begin
        if (op_q == mma_pkg::OP_EQ) begin
          eq_q <= (ra == rb);
        end else if (op_q == mma_pkg::OP_ADD || op_q == mma_pkg::OP_SUB ||
                     op_q == mma_pkg::OP_NEG) begin
          res_q <= smp_fix;
        end
      end
      S_DIVW: begin
        if (div_stat.done) begin
          t_q <= pv_q[WW-1] ? WW'(m32 - W'(div_rem)) : WW'(m32 + W'(div_rem));
        end
      end
      S_TLD: t_q <= prod;
      S_RC: begin
        case (dst_q)
          DST_PLAIN: res_q <= rr;
          DST_X1: begin
            x1_q <= rr;
            y1_q <= m;
            x2_q <= W'(1);
            y2_q <= '0;
          end
          DST_TM: begin
            res_q  <= r;
            acc_q  <= r;
            base_q <= W'(a_q);
          end
          DST_ACC:  acc_q <= r;
          DST_BASE: begin
            base_q <= r;
            e_q    <= e_q >> 1;
          end
          default:  res_q <= r;
        endcase
      end
      S_EU: if (y1_q == '0) pv_q <= WW'(signed'(x2_q));
      S_EUM: begin
        x1_q <= W'(y1_q);
        y1_q <= div_rem;
        x2_q <= y2_q;
        y2_q <= x2_q - prod[W-1:0];
      end
      S_PW: if (e_q == '0) res_q <= acc_q;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      out_res_q <= res_q[VW-1:0];
      out_eq_q  <= eq_q;
    end
  end

  `MMA_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, state_q != S_IDLE, "item accepted but sequencer stayed idle")
  `MMA_ASSERT_IMPL(a_div_in_wait, clk_i, rst_ni, div_stat.busy, (state_q == S_DIVW || state_q == S_EUW), "divider running outside a wait state")
  `MMA_ASSERT_IMPL(a_eq_zero_res, clk_i, rst_ni, out_valid_q && out_eq_q, out_res_q == '0, "equal flag with nonzero result")

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import mma_pkg::*;

  localparam logic [OPW-1:0] OP_SPARE_LO = 4'd10;
  localparam logic [OPW-1:0] OP_SPARE_HI = 4'd15;
  localparam int unsigned PHASES = 5;
  localparam int unsigned RAND_PER_PHASE = 160;

  typedef struct {
    logic [OPW-1:0]          op;
    logic [VALW-1:0]         a;
    logic [VALW-1:0]         b;
    logic [WIDEW-1:0]        e;
    logic signed [WIDEW-1:0] pv;
  } alu_op_t;

  typedef struct {
    logic [VALW-1:0] res;
    logic            eq;
  } alu_res_t;

  logic clk;
  logic rst_n;

  mma_in_if  in_if();
  mma_out_if out_if();
  mma_cfg_if cfg_if();

  montgomery_modular_alu dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Register shadow, updated on each config transfer
  logic [29:0] cur_mod;
  logic [31:0] cur_ninv;
  logic [29:0] cur_r2;

  alu_op_t  pend_q[$];
  alu_res_t exp_q[$];
  int       errs;
  int       src_idle;
  int       snk_idle;
  int       hold_cnt;
  logic     hold_go;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- arithmetic model ----------------
  function automatic logic [31:0] eff_mod();
    return {2'b00, cur_mod} | 32'd1;
  endfunction

  function automatic logic [31:0] redc(logic [63:0] t);
    logic [31:0] u;
    logic [63:0] s;
    u = t[31:0] * cur_ninv;
    s = t + {32'd0, u} * {32'd0, eff_mod()};
    return s[63:32];
  endfunction

  function automatic logic [31:0] into_mont(logic [63:0] raw);
    logic [63:0] m, mag, rem, t;
    m = {32'd0, eff_mod()};
    mag = raw[63] ? (64'd0 - raw) : raw;
    rem = mag % m;
    t = raw[63] ? (m - rem) : (m + rem);
    return redc(t * {34'd0, cur_r2});
  endfunction

  function automatic logic [31:0] out_of_mont(logic [31:0] a);
    logic [31:0] r;
    r = redc({32'd0, a});
    return (r >= eff_mod()) ? r - eff_mod() : r;
  endfunction

  // Fold a wrapped difference back into [0, 2m)
  function automatic logic [30:0] fold_2m(logic [31:0] v);
    logic [31:0] w;
    w = v;
    if (w[31]) w = w + 2 * eff_mod();
    return w[30:0];
  endfunction

  // Extended Euclid on the plain residue, back into Montgomery form
  function automatic logic [31:0] mont_inverse(logic [31:0] a);
    longint x1, y1, x2, y2, q, t;
    x1 = longint'(out_of_mont(a));
    y1 = longint'(eff_mod());
    x2 = 1;
    y2 = 0;
    while (y1 > 0) begin
      q = x1 / y1;
      x2 = x2 - q * y2;
      x1 = x1 % y1;
      t = x1; x1 = y1; y1 = t;
      t = x2; x2 = y2; y2 = t;
    end
    return into_mont(x2);
  endfunction

  function automatic logic [31:0] mont_power(logic [31:0] a, logic [63:0] e);
    logic [31:0] acc, base;
    logic [63:0] k;
    acc = into_mont(64'd1);
    base = a;
    k = e;
    while (k != 0) begin
      if (k[0]) acc = redc({32'd0, acc} * {32'd0, base});
      base = redc({32'd0, base} * {32'd0, base});
      k = k >> 1;
    end
    return acc;
  endfunction

  function automatic alu_res_t alu_predict(alu_op_t it);
    alu_res_t r;
    logic [31:0] m, a, b, ra, rb, v;
    m = eff_mod();
    a = {1'b0, it.a};
    b = {1'b0, it.b};
    v = 32'd0;
    r.eq = 1'b0;
    case (it.op)
      OP_TOMONT:  v = into_mont(it.pv);
      OP_ADD:     v = fold_2m(a + b - 2 * m);
      OP_SUB:     v = fold_2m(a - b);
      OP_MUL:     v = redc({32'd0, a} * {32'd0, b});
      OP_DIV:     v = redc({32'd0, a} * {32'd0, mont_inverse(b)});
      OP_POW:     v = mont_power(a, it.e);
      OP_INV:     v = mont_inverse(a);
      OP_TOPLAIN: v = out_of_mont(a);
      OP_EQ: begin
        ra = (a >= m) ? a - m : a;
        rb = (b >= m) ? b - m : b;
        r.eq = (ra == rb);
      end
      OP_NEG:     v = fold_2m(32'd0 - a);
      default:    v = 32'd0;
    endcase
    r.res = v[30:0];
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [30:0] rand_operand();
    logic [31:0] m2;
    m2 = 2 * eff_mod();
    if ($urandom_range(99) < 85) return 31'($urandom_range(m2 - 1, 0));
    return 31'($urandom);
  endfunction

  function automatic alu_op_t rand_item();
    alu_op_t it;
    int w;
    w = $urandom_range(99);
    if (w < 12) it.op = OP_TOMONT;
    else if (w < 24) it.op = OP_ADD;
    else if (w < 36) it.op = OP_SUB;
    else if (w < 50) it.op = OP_MUL;
    else if (w < 55) it.op = OP_DIV;
    else if (w < 66) it.op = OP_POW;
    else if (w < 71) it.op = OP_INV;
    else if (w < 80) it.op = OP_TOPLAIN;
    else if (w < 89) it.op = OP_EQ;
    else if (w < 97) it.op = OP_NEG;
    else it.op = OPW'($urandom_range(15, 10));
    it.a = rand_operand();
    it.b = rand_operand();
    // Congruent pair now and then so eq hits both outcomes
    if (it.op == OP_EQ && $urandom_range(1)) it.b = (it.a >= eff_mod()) ?
        31'(it.a - eff_mod()) : 31'(it.a + eff_mod());
    it.e = {$urandom, $urandom} >> $urandom_range(63);
    it.pv = {$urandom, $urandom} >>> $urandom_range(63);
    if ($urandom_range(1)) it.pv = -it.pv;
    return it;
  endfunction

  function automatic alu_op_t mk(logic [OPW-1:0] op, logic [30:0] a, logic [30:0] b,
                                 logic [63:0] e, logic [63:0] pv);
    alu_op_t it;
    it.op = op; it.a = a; it.b = b; it.e = e; it.pv = pv;
    return it;
  endfunction

  task automatic report(string what, logic [30:0] got, logic [30:0] want);
    errs++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // ---------------- request driver ----------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid       <= 1'b0;
      in_if.opcode      <= '0;
      in_if.operand_a   <= '0;
      in_if.operand_b   <= '0;
      in_if.exponent    <= '0;
      in_if.plain_value <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        exp_q.push_back(alu_predict(pend_q.pop_front()));
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered item
      end else if (pend_q.size() > 0 && $urandom_range(99) >= src_idle) begin
        in_if.valid       <= 1'b1;
        in_if.opcode      <= pend_q[0].op;
        in_if.operand_a   <= pend_q[0].a;
        in_if.operand_b   <= pend_q[0].b;
        in_if.exponent    <= pend_q[0].e;
        in_if.plain_value <= pend_q[0].pv;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, in cycles
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) hold_cnt <= 0;
    else if (hold_go) hold_cnt <= 3000;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // ---------------- result monitor ----------------
  always @(posedge clk or negedge rst_n) begin
    alu_res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (exp_q.size() == 0) begin
          report("unexpected result", out_if.result, '0);
        end else begin
          want = exp_q.pop_front();
          if (out_if.result !== want.res) report("result", out_if.result, want.res);
          if (out_if.equal !== want.eq) report("equal", 31'(out_if.equal), 31'(want.eq));
        end
      end
      out_if.ready <= (hold_cnt == 0) && ($urandom_range(99) >= snk_idle);
    end
  end

  // ---------------- configuration ----------------
  task automatic cfg_write(logic [CFGAW-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_MODULUS: cur_mod  = val[29:0];
      CFG_NEG_INV: cur_ninv = val;
      CFG_R2:      cur_r2   = val[29:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Program a modulus along with constants derived from its odd version
  task automatic set_modulus(logic [29:0] mval);
    logic [31:0] m, inv;
    logic [63:0] r;
    m = {2'b00, mval} | 32'd1;
    inv = m;
    repeat (5) inv = inv * (32'd2 - m * inv);
    r = (64'd1 << 32) % m;
    cfg_write(CFG_MODULUS, {2'b00, mval});
    cfg_write(CFG_NEG_INV, 32'd0 - inv);
    cfg_write(CFG_R2, 32'((r * r) % m));
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || exp_q.size() > 0 || in_if.valid) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------- sequence ----------------
  initial begin
    logic [29:0] mods[PHASES];
    int s_idle[PHASES];
    int r_idle[PHASES];
    logic [30:0] top;
    mods = '{30'h3FFF_FFFF, 30'd1000, 30'd3, 30'd0, 30'd0};
    s_idle = '{0, 0, 54, 0, 22};
    r_idle = '{0, 0, 0, 54, 22};
    errs = 0;
    src_idle = 0;
    snk_idle = 0;
    hold_go = 1'b0;
    cur_mod = 30'd1;
    cur_ninv = 32'hFFFF_FFFF;
    cur_r2 = 30'd0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: modulus one
    pend_q.push_back(mk(OP_TOMONT, 31'd0, 31'd0, 64'd0, 64'd12345));
    pend_q.push_back(mk(OP_ADD, 31'd1, 31'd1, 64'd0, 64'd0));
    drain();

    mods[4] = 30'($urandom_range(30'h3FFF_FFFF, 3)) | 30'd1;
    for (int p = 0; p < PHASES; p++) begin
      set_modulus(mods[p]);
      src_idle = s_idle[p];
      snk_idle = r_idle[p];
      if (p == 0) begin
        top = 31'(2 * eff_mod() - 1);
        pend_q.push_back(mk(OP_TOMONT, '0, '0, '0, 64'h8000_0000_0000_0000));
        pend_q.push_back(mk(OP_TOMONT, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF));
        pend_q.push_back(mk(OP_TOMONT, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF));
        pend_q.push_back(mk(OP_TOMONT, '0, '0, '0, 64'd0));
        pend_q.push_back(mk(OP_ADD, top, top, '0, '0));
        pend_q.push_back(mk(OP_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '0, '0));
        pend_q.push_back(mk(OP_SUB, 31'd0, top, '0, '0));
        pend_q.push_back(mk(OP_SUB, top, 31'd0, '0, '0));
        pend_q.push_back(mk(OP_MUL, top, top, '0, '0));
        pend_q.push_back(mk(OP_MUL, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '0, '0));
        pend_q.push_back(mk(OP_DIV, 31'd12345, 31'd0, '0, '0));
        pend_q.push_back(mk(OP_DIV, top, 31'd777, '0, '0));
        pend_q.push_back(mk(OP_POW, 31'd99, '0, 64'd0, '0));
        pend_q.push_back(mk(OP_POW, top, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0));
        pend_q.push_back(mk(OP_INV, 31'd0, '0, '0, '0));
        pend_q.push_back(mk(OP_INV, 31'(eff_mod()), '0, '0, '0));
        pend_q.push_back(mk(OP_INV, 31'd5, '0, '0, '0));
        pend_q.push_back(mk(OP_TOPLAIN, top, '0, '0, '0));
        pend_q.push_back(mk(OP_TOPLAIN, 31'h7FFF_FFFF, '0, '0, '0));
        pend_q.push_back(mk(OP_EQ, 31'd7, 31'(eff_mod() + 7), '0, '0));
        pend_q.push_back(mk(OP_EQ, 31'd7, 31'd8, '0, '0));
        pend_q.push_back(mk(OP_NEG, 31'd0, '0, '0, '0));
        pend_q.push_back(mk(OP_NEG, top, '0, '0, '0));
        pend_q.push_back(mk(OP_SPARE_LO, top, top, '1, '1));
        pend_q.push_back(mk(OP_SPARE_HI, top, top, '1, '1));
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) pend_q.push_back(rand_item());
      if (p == 1) begin
        // stall the result side while requests keep coming
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errs == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Run limit
  initial begin
    #300ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== montgomery_modular_alu.f =====
+incdir+sv
sv/mma_pkg.sv
sv/mma_intf.sv
sv/mma_mul.sv
sv/mma_div.sv
sv/montgomery_modular_alu.sv
test/tb_top.sv
